// ===== sv/kvlt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvlt_pkg: shared types and constants of the key/value line tokenizer
// Parse state and result kind codes, character codes, counter widths and the
// result bundle that the parser hands to the top level.
// ----------------------------------------------------------------------------
package kvlt_pkg;

   // Longest token, in bytes, before an overflow is reported
   localparam int MAX_TOKEN = 512;
   // Token counters must hold MAX_TOKEN itself
   localparam int CNT_W     = $clog2(MAX_TOKEN + 1);
   // Width of the length field on the result port
   localparam int LEN_W     = 10;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 3;

   localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB  = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_VT   = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF   = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SP   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_EQ   = 8'h3D;

   typedef enum logic [2:0] {
      ST_READY    = 3'd0,
      ST_KEY      = 3'd1,
      ST_AFTER_EQ = 3'd2,
      ST_VALUE    = 3'd3,
      ST_COMMENT  = 3'd4,
      ST_SKIP     = 3'd5
   } parse_state_type;

   typedef enum logic [KIND_W-1:0] {
      K_KEY_BYTE   = 3'd0,
      K_VALUE_BYTE = 3'd1,
      K_KEY_END    = 3'd2,
      K_VALUE_END  = 3'd3,
      K_SYNTAX     = 3'd4,
      K_OVERFLOW   = 3'd5,
      K_INPUT_END  = 3'd6
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      logic [LEN_W-1:0]  token_length;
      logic              end_of_input;
   } result_type;

endpackage

// ===== sv/key_value_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_top: streaming key=value line tokenizer
// Registers each text byte, parses it against the current state and registers
// the resulting key/value byte, end marker or error for the consumer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_text_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_kind, rsp_out_byte,
//                                            rsp_token_length, rsp_end_of_input
//
// One byte per cycle sustained unless rsp stalls; an accepted byte passes
// two register stages in turn: input register, then result register.
// The parse state and two token counters update in the same cycle the byte
// moves into the result register, so consecutive bytes follow back to back.
// Reset is synchronous and returns the parser to ready with empty stages.
// A stall on rsp holds the result register; an empty input register still takes
// one more transaction, then req_stall rises until the result drains.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kvlt_pkg::BYTE_W-1:0]       req_text_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kvlt_pkg::KIND_W-1:0]       rsp_kind,
   output logic [kvlt_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [kvlt_pkg::LEN_W-1:0]        rsp_token_length,
   output logic                              rsp_end_of_input
);
   import kvlt_pkg::*;

   // Input register stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Result register stage
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;

   result_type        step_result;
   logic              advance;
   logic              req_take;

   // Advance the held byte when the result register is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Stall the producer only when the held byte cannot move on
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         // A byte with no result leaves the result register empty
         out_valid_in = step_result.valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   kvlt_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .text_byte (in_byte_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = KIND_W'(out_ff.kind);
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_token_length = out_ff.token_length;
   assign rsp_end_of_input = out_ff.end_of_input;

endmodule

// ===== sv/kvlt_parser.sv =====
// ----------------------------------------------------------------------------
// kvlt_parser: parse state machine and token counters
// Takes one byte per enabled cycle, updates the parse state and the token and
// trimmed counters, and produces at most one result for that byte.
// ----------------------------------------------------------------------------
module kvlt_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [kvlt_pkg::BYTE_W-1:0]    text_byte,
   output kvlt_pkg::result_type           result
);
   import kvlt_pkg::*;

   parse_state_type   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  trim_ff, trim_in;
   logic [CNT_W-1:0]  count_plus;
   logic              is_blank;
   logic              is_nul;
   logic              is_line_end;
   logic              token_full;

   assign is_blank    = (text_byte == CHAR_SP) || (text_byte == CHAR_TAB) ||
                        (text_byte == CHAR_LF) || (text_byte == CHAR_VT) ||
                        (text_byte == CHAR_FF) || (text_byte == CHAR_CR);
   assign is_nul      = (text_byte == CHAR_NUL);
   assign is_line_end = (text_byte == CHAR_LF) || (text_byte == CHAR_CR);
   assign token_full  = (count_ff >= CNT_W'(MAX_TOKEN));
   assign count_plus  = count_ff + CNT_W'(1);

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      trim_in  = trim_ff;
      unique case (state_ff)
         ST_KEY: begin
            if (text_byte == CHAR_EQ) begin
               state_in = ST_AFTER_EQ;
               count_in = '0;
               trim_in  = '0;
            end else if (is_nul || text_byte == CHAR_LF) begin
               state_in = ST_READY;
               count_in = '0;
               trim_in  = '0;
            end else if (token_full) begin
               state_in = ST_SKIP;
            end else begin
               count_in = count_plus;
               if (!is_blank) begin
                  trim_in = count_plus;
               end
            end
         end
         ST_AFTER_EQ: begin
            if (is_nul) begin
               state_in = ST_READY;
               count_in = '0;
               trim_in  = '0;
            end else if (!is_blank) begin
               state_in = ST_VALUE;
               count_in = CNT_W'(1);
               trim_in  = CNT_W'(1);
            end
         end
         ST_VALUE: begin
            if (is_nul || is_line_end || text_byte == CHAR_HASH) begin
               state_in = (text_byte == CHAR_HASH) ? ST_COMMENT : ST_READY;
               count_in = '0;
               trim_in  = '0;
            end else if (token_full) begin
               state_in = ST_SKIP;
            end else begin
               count_in = count_plus;
               if (!is_blank) begin
                  trim_in = count_plus;
               end
            end
         end
         ST_COMMENT, ST_SKIP: begin
            if (is_nul || is_line_end) begin
               state_in = ST_READY;
               count_in = '0;
               trim_in  = '0;
            end
         end
         default: begin
            // Ready, and unused codes that behave as ready
            if (is_nul) begin
               state_in = ST_READY;
               count_in = '0;
               trim_in  = '0;
            end else if (is_blank) begin
               state_in = ST_READY;
            end else if (text_byte == CHAR_HASH) begin
               state_in = ST_COMMENT;
            end else begin
               state_in = ST_KEY;
               count_in = CNT_W'(1);
               trim_in  = CNT_W'(1);
            end
         end
      endcase
   end

   // Result for the current byte
   always_comb begin
      result = '{valid: 1'b0, kind: K_KEY_BYTE, out_byte: '0,
                 token_length: '0, end_of_input: 1'b0};
      unique case (state_ff)
         ST_KEY: begin
            result.valid = 1'b1;
            if (text_byte == CHAR_EQ) begin
               result.kind         = K_KEY_END;
               result.token_length = LEN_W'(trim_ff);
            end else if (is_nul || text_byte == CHAR_LF) begin
               result.kind         = K_SYNTAX;
               result.end_of_input = is_nul;
            end else if (token_full) begin
               result.kind = K_OVERFLOW;
            end else begin
               result.kind     = K_KEY_BYTE;
               result.out_byte = text_byte;
            end
         end
         ST_AFTER_EQ: begin
            if (is_nul) begin
               result.valid        = 1'b1;
               result.kind         = K_SYNTAX;
               result.end_of_input = 1'b1;
            end else if (!is_blank) begin
               result.valid    = 1'b1;
               result.kind     = K_VALUE_BYTE;
               result.out_byte = text_byte;
            end
         end
         ST_VALUE: begin
            result.valid = 1'b1;
            if (is_nul || is_line_end || text_byte == CHAR_HASH) begin
               result.kind         = K_VALUE_END;
               result.token_length = LEN_W'(trim_ff);
               result.end_of_input = is_nul;
            end else if (token_full) begin
               result.kind = K_OVERFLOW;
            end else begin
               result.kind     = K_VALUE_BYTE;
               result.out_byte = text_byte;
            end
         end
         ST_COMMENT, ST_SKIP: begin
            if (is_nul) begin
               result.valid        = 1'b1;
               result.kind         = K_INPUT_END;
               result.end_of_input = 1'b1;
            end
         end
         default: begin
            if (is_nul) begin
               result.valid        = 1'b1;
               result.kind         = K_INPUT_END;
               result.end_of_input = 1'b1;
            end else if (!is_blank && text_byte != CHAR_HASH) begin
               result.valid    = 1'b1;
               result.kind     = K_KEY_BYTE;
               result.out_byte = text_byte;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         count_ff <= '0;
         trim_ff  <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         count_ff <= count_in;
         trim_ff  <= trim_in;
      end
   end

   // Trimmed length never runs past the raw token length
   a_trim_le_count: assert property (@(posedge clock) disable iff (reset)
      trim_ff <= count_ff)
      else $error("trimmed count exceeds token count");

   // Token never grows past the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TOKEN))
      else $error("token count above limit");

   // Ready always starts from cleared counters
   a_ready_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READY |-> count_ff == '0 && trim_ff == '0)
      else $error("counters not cleared in ready");

   // An overflow drops the rest of the line
   a_overflow_skip: assert property (@(posedge clock) disable iff (reset)
      step_en && result.valid && result.kind == K_OVERFLOW |=> state_ff == ST_SKIP)
      else $error("overflow did not enter skip");

   // Only the terminating kinds may close the input
   a_eoi_kind: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.end_of_input |->
         result.kind == K_SYNTAX || result.kind == K_VALUE_END ||
         result.kind == K_INPUT_END)
      else $error("end of input on a non-terminating kind");

endmodule
